@@ design/arpc_pkg.sv @@
package arpc_pkg;

  // Reflected CRC-32 polynomial.
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;

  // Alignment of a band in bytes, the default of the top-level parameter.
  localparam int unsigned ALIGN_BYTES_DEFAULT = 16;

  // Width of a per-item byte count: four data bytes plus up to 63 padding bytes.
  localparam int unsigned CNT_W = 7;

  // Depth of the queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);

  // Configuration register indexes.
  typedef enum logic {
    REG_DROP = 1'b0,
    REG_SEED = 1'b1
  } reg_idx_e;

  // One input request.
  typedef struct packed {
    logic signed [31:0] acc_value;
    logic               final_item;
  } in_item_t;

  // One result byte.
  typedef struct packed {
    logic [7:0]  packed_byte;
    logic        band_end;
    logic [31:0] crc_out;
  } out_item_t;

  // A classified accumulator, ready to be serialized into bytes.
  typedef struct packed {
    logic [31:0]      value;
    logic [2:0]       nb;
    logic [CNT_W-1:0] total;
    logic             last;
    logic [31:0]      crc;
  } job_t;

  // One byte step of the reflected CRC, in the inverted domain.
  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'b0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'b0);
    end
    return c;
  endfunction

  // Number of bytes that hold a value shifted right by drop bits:
  // ceil((32 - drop) / 8), which is four minus the whole bytes dropped.
  function automatic logic [2:0] bytes_each(input logic [4:0] drop);
    return 3'd4 - {1'b0, drop[4:3]};
  endfunction

endpackage

@@ design/arpc_front.sv @@
module arpc_front #(
  parameter int unsigned ALIGN_BYTES = arpc_pkg::ALIGN_BYTES_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  arpc_pkg::in_item_t in_item_i,
  input  logic [4:0]         drop_i,
  input  logic [31:0]        seed_i,
  output logic               job_valid_o,
  input  logic               job_full_i,
  output arpc_pkg::job_t     job_o
);

  localparam int unsigned PW = (ALIGN_BYTES > 1) ? $clog2(ALIGN_BYTES) : 1;
  localparam int unsigned SW = $clog2(ALIGN_BYTES + 4);
  localparam logic [SW-1:0] ALIGN_S = SW'(ALIGN_BYTES);

  logic                         busy_q, busy_d;
  logic [1:0]                   step_q, step_d;
  logic                         band_open_q, band_open_d;
  logic [PW-1:0]                phase_q, phase_d;
  logic [31:0]                  c_q, c_d;
  logic [31:0]                  word_q, value_q;
  logic [2:0]                   nb_q;
  logic [arpc_pkg::CNT_W-1:0]   total_q;
  logic                         last_q;

  logic        accept, advance, push_job;
  logic [31:0] crc_next, start_c;
  logic [31:0] v_new, back_new;
  logic [2:0]  nb_new;
  logic [SW-1:0] used, pad;

  // One CRC byte per cycle over the reconstructed word while the queue has room.
  assign crc_next = arpc_pkg::crc_byte(c_q, 8'(word_q >> {step_q, 3'b000}));
  assign push_job = busy_q && (step_q == 2'd3) && !job_full_i;
  assign advance  = busy_q && ((step_q != 2'd3) || push_job);
  assign full_o   = busy_q && !push_job;
  assign accept   = push_i && !full_o;

  // Classify the incoming accumulator: shift, byte count and padding.
  always_comb begin
    v_new    = 32'($signed(in_item_i.acc_value) >>> drop_i);
    back_new = v_new << drop_i;
    nb_new   = arpc_pkg::bytes_each(drop_i);
    used     = SW'(phase_q) + SW'(nb_new);
    for (int i = 0; i < 4; i++) begin
      if (used >= ALIGN_S) begin
        used = used - ALIGN_S;
      end
    end
    pad = '0;
    if (in_item_i.final_item && (used != '0)) begin
      pad = ALIGN_S - used;
    end
  end

  // A running band continues from the CRC of the previous item, else from the seed.
  always_comb begin
    if (band_open_q) begin
      start_c = push_job ? crc_next : c_q;
    end else begin
      start_c = ~seed_i;
    end
  end

  // Sequencing of the CRC unit and the band state.
  always_comb begin
    busy_d      = busy_q;
    step_d      = step_q;
    c_d         = c_q;
    band_open_d = band_open_q;
    phase_d     = phase_q;
    if (advance) begin
      c_d = crc_next;
      if (step_q == 2'd3) begin
        busy_d = 1'b0;
      end else begin
        step_d = step_q + 2'd1;
      end
    end
    if (accept) begin
      busy_d      = 1'b1;
      step_d      = 2'd0;
      c_d         = start_c;
      band_open_d = !in_item_i.final_item;
      phase_d     = in_item_i.final_item ? '0 : PW'(used);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= 2'd0;
      band_open_q <= 1'b0;
      phase_q     <= '0;
    end else begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      band_open_q <= band_open_d;
      phase_q     <= phase_d;
    end
  end

  // Running CRC and the payload of the item in flight.
  always_ff @(posedge clk_i) begin
    c_q <= c_d;
    if (accept) begin
      word_q  <= back_new;
      value_q <= v_new;
      nb_q    <= nb_new;
      total_q <= arpc_pkg::CNT_W'(nb_new) + arpc_pkg::CNT_W'(pad);
      last_q  <= in_item_i.final_item;
    end
  end

  assign job_valid_o = push_job;
  assign job_o.value = value_q;
  assign job_o.nb    = nb_q;
  assign job_o.total = total_q;
  assign job_o.last  = last_q;
  assign job_o.crc   = ~crc_next;

endmodule

@@ design/arpc_queue.sv @@
module arpc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  arpc_pkg::job_t wr_data_i,
  output logic           full_o,
  input  logic           rd_i,
  output logic           empty_o,
  output arpc_pkg::job_t rd_data_o
);

  localparam logic [arpc_pkg::QPTR_W:0] DEPTH_C = (arpc_pkg::QPTR_W + 1)'(arpc_pkg::QUEUE_DEPTH);

  arpc_pkg::job_t                mem_q [arpc_pkg::QUEUE_DEPTH];
  logic [arpc_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [arpc_pkg::QPTR_W:0]     count_q;
  logic                          do_wr, do_rd;

  assign full_o    = (count_q == DEPTH_C);
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

@@ design/arpc_back.sv @@
module arpc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_empty_i,
  input  arpc_pkg::job_t      job_i,
  output logic                job_pop_o,
  output logic                empty_o,
  input  logic                pop_i,
  output arpc_pkg::out_item_t out_item_o
);

  logic                       out_valid_q;
  arpc_pkg::out_item_t        out_q;
  logic [arpc_pkg::CNT_W-1:0] cnt_q;
  logic                       load, last_byte, is_data;
  logic [arpc_pkg::CNT_W-1:0] cnt_inc;

  // The output register takes a new byte when it is free or being drained.
  assign load      = !job_empty_i && (!out_valid_q || pop_i);
  assign cnt_inc   = cnt_q + 1'b1;
  assign last_byte = (cnt_inc == job_i.total);
  assign is_data   = (cnt_q < arpc_pkg::CNT_W'(job_i.nb));
  assign job_pop_o = load && last_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        cnt_q       <= last_byte ? '0 : cnt_inc;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Data bytes go little-endian, then zero padding.
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.packed_byte <= is_data ? 8'(job_i.value >> {cnt_q[1:0], 3'b000}) : 8'd0;
      out_q.band_end    <= job_i.last && last_byte;
      out_q.crc_out     <= job_i.crc;
    end
  end

  assign empty_o    = !out_valid_q;
  assign out_item_o = out_q;

endmodule

@@ design/accumulator_requant_packer_crc.sv @@
// Accumulator requantizer and byte packer with a running CRC-32.
//
// Input side: a queue-style port. An accumulator request is taken when push is
// high and full is low. Each value is shifted arithmetically right by the
// drop_bits register and sent as one to four little-endian bytes; the last
// accumulator of a band pads the byte stream with zeros to ALIGN_BYTES.
// Output side: one byte per request on out_data_o while empty is low, taken
// with pop. Every byte carries the CRC after its accumulator; band_end marks
// the final byte of a band, whose CRC is the band's final value.
// Configuration: APB at byte addresses 0 (drop_bits) and 4 (crc_seed), to be
// written by the user only while the block is idle; the block does not
// enforce this. pready is always high. The CRC unit folds one byte per cycle
// while the queue has room, and an accepted accumulator passes through it,
// the queue and the output register. A two-entry queue lets the input keep
// running while the output stalls; full is high while the CRC unit folds an
// item and drops in its last cycle unless the queue is full. Reset clears
// the band state: the next accumulator starts from crc_seed and the band's
// byte count is zero. Both registers reset to zero.
module accumulator_requant_packer_crc #(
  parameter int unsigned ALIGN_BYTES = arpc_pkg::ALIGN_BYTES_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                push,
  output logic                full,
  input  arpc_pkg::in_item_t  in_data_i,
  output logic                empty,
  input  logic                pop,
  output arpc_pkg::out_item_t out_data_o
);

  logic [4:0]        drop_q;
  logic [31:0]       seed_q;
  logic              cfg_wr;
  arpc_pkg::reg_idx_e reg_idx;

  logic              job_valid, job_full, job_empty, job_pop;
  arpc_pkg::job_t    job_in, job_head;

  // Configuration registers.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = arpc_pkg::reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_q <= 5'd0;
      seed_q <= 32'd0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        arpc_pkg::REG_DROP: drop_q <= pwdata[4:0];
        arpc_pkg::REG_SEED: seed_q <= pwdata;
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      arpc_pkg::REG_DROP: prdata = {27'd0, drop_q};
      arpc_pkg::REG_SEED: prdata = seed_q;
      default:            prdata = 32'd0;
    endcase
  end

  arpc_front #(
    .ALIGN_BYTES(ALIGN_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .in_item_i  (in_data_i),
    .drop_i     (drop_q),
    .seed_i     (seed_q),
    .job_valid_o(job_valid),
    .job_full_i (job_full),
    .job_o      (job_in)
  );

  arpc_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (job_valid),
    .wr_data_i(job_in),
    .full_o   (job_full),
    .rd_i     (job_pop),
    .empty_o  (job_empty),
    .rd_data_o(job_head)
  );

  arpc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_empty_i(job_empty),
    .job_i      (job_head),
    .job_pop_o  (job_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_item_o (out_data_o)
  );

endmodule
